### design/color_spec_stream_parser_macros.svh
// Assertion macros for the color name parser.
// Used by the top level; expects clk and rst_n in scope.
`ifndef COLOR_SPEC_STREAM_PARSER_MACROS_SVH
`define COLOR_SPEC_STREAM_PARSER_MACROS_SVH

// Checked only while out of reset.
`define CSSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define CSSP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/cssp_pkg.sv
// Shared types, word table and level scaling functions of the color name parser.
// No dependencies.
package cssp_pkg;

  typedef enum logic [1:0] {
    ST_VALID   = 2'd0,
    ST_INVALID = 2'd1,
    ST_RGBI    = 2'd2
  } parse_status_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } cssp_in_t;

  typedef struct packed {
    logic [15:0]   red_level;
    logic [15:0]   green_level;
    logic [15:0]   blue_level;
    parse_status_t parse_status;
  } cssp_out_t;

  localparam int WORD_COUNT = 8;
  localparam int WORD_TEXT_LEN = 6;
  localparam int WORD_RGB = 0;
  localparam int WORD_GRAY = 1;
  localparam int WORD_FIRST_NAME = 2;

  localparam logic [7:0] WORD_TEXT [WORD_COUNT][WORD_TEXT_LEN] = '{
    '{"r", "g", "b", 8'h00, 8'h00, 8'h00},
    '{"g", "r", "a", "y", 8'h00, 8'h00},
    '{"b", "l", "a", "c", "k", 8'h00},
    '{"w", "h", "i", "t", "e", 8'h00},
    '{"r", "e", "d", 8'h00, 8'h00, 8'h00},
    '{"g", "r", "e", "e", "n", 8'h00},
    '{"b", "l", "u", "e", 8'h00, 8'h00},
    '{"y", "e", "l", "l", "o", "w"}
  };

  localparam logic [2:0] WORD_LEN [WORD_COUNT] = '{
    3'd3, 3'd4, 3'd5, 3'd5, 3'd3, 3'd5, 3'd4, 3'd6
  };

  localparam logic [15:0] WORD_RED [WORD_COUNT] = '{
    16'd0, 16'd0, 16'd0, 16'd65535, 16'd65535, 16'd0, 16'd0, 16'd65535
  };
  localparam logic [15:0] WORD_GREEN [WORD_COUNT] = '{
    16'd0, 16'd0, 16'd0, 16'd65535, 16'd0, 16'd32896, 16'd0, 16'd65535
  };
  localparam logic [15:0] WORD_BLUE [WORD_COUNT] = '{
    16'd0, 16'd0, 16'd0, 16'd65535, 16'd0, 16'd0, 16'd65535, 16'd0
  };

  // Scales a group of one to four hex digits to 16 bits with rounding.
  function automatic logic [15:0] scale_group(input logic [15:0] v, input logic [2:0] digits);
    logic [15:0] t;
    logic [3:0]  q;
    logic [15:0] res;
    t = 16'({4'd0, v[11:0]} << 4) - {4'd0, v[11:0]} + 16'd2047;
    q = 4'd0;
    for (int k = 1; k < 16; k++) begin
      if (t >= 16'(k * 4095)) q = 4'(k);
    end
    case (digits)
      3'd1: res = {v[3:0], v[3:0], v[3:0], v[3:0]};
      3'd2: res = {v[7:0], v[7:0]};
      3'd3: res = {v[11:0], q};
      3'd4: res = v;
      default: res = 16'd0;
    endcase
    return res;
  endfunction

  // Converts a percent from 0 to 100 to a 16-bit gray level.
  function automatic logic [15:0] gray_level(input logic [6:0] p);
    logic [14:0] x;
    logic [27:0] prod;
    x = 15'({8'd0, p} << 8) - {8'd0, p} + 15'd50;
    prod = {13'd0, x} * 28'd5243;
    return {prod[26:19], prod[26:19]};
  endfunction

endpackage

### design/cssp_core.sv
// Parser state and per-character next-state and result logic.
// Depends on cssp_pkg.
module cssp_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  cssp_pkg::cssp_in_t   step_in,
  output cssp_pkg::cssp_out_t  step_out
);
  import cssp_pkg::*;

  typedef enum logic [3:0] {
    MODE_START      = 4'd0,
    MODE_WORD       = 4'd1,
    MODE_HASH       = 4'd2,
    MODE_RGB        = 4'd3,
    MODE_RGBI_COLON = 4'd4,
    MODE_RGBI       = 4'd5,
    MODE_GRAY       = 4'd6,
    MODE_BAD        = 4'd7
  } form_mode_t;

  localparam int PF_NEG = 0;
  localparam int PF_SIGN = 1;
  localparam int PF_DIGIT = 2;

  form_mode_t  mode_r, mode_nxt;
  logic [4:0]  pos_r, pos_nxt;
  logic [47:0] hash_r, hash_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [1:0]  gidx_r, gidx_nxt;
  logic [15:0] first_r, first_nxt;
  logic [15:0] second_r, second_nxt;
  logic [6:0]  pct_r, pct_nxt;
  logic [2:0]  flags_r, flags_nxt;
  logic [7:0]  cand_r, cand_nxt;

  logic [7:0]  c;
  logic [7:0]  lc;
  logic        hex_ok;
  logic [3:0]  hex_val;
  logic [7:0]  cand_in;
  logic [7:0]  keep;
  logic [9:0]  pct_sum;
  logic [15:0] slash_level;
  logic [15:0] grp_r, grp_g, grp_b;
  logic [2:0]  grp_digits;

  always_comb begin
    c = step_in.char_code;
    lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    hex_ok = 1'b1;
    hex_val = 4'd0;
    if (c >= "0" && c <= "9") begin
      hex_val = 4'(c - "0");
    end else if (lc >= "a" && lc <= "f") begin
      hex_val = 4'(lc - "a" + 8'd10);
    end else begin
      hex_ok = 1'b0;
    end
  end

  always_comb begin
    cand_in = (mode_r == MODE_START) ? 8'hFF : cand_r;
    for (int i = 0; i < WORD_COUNT; i++) begin
      keep[i] = cand_in[i] && (pos_r < {2'b00, WORD_LEN[i]}) &&
                ((lc == WORD_TEXT[i][pos_r[2:0]]) ||
                 (i == WORD_GRAY && pos_r == 5'd2 && lc == "e"));
    end
  end

  assign pct_sum = {3'd0, pct_r} * 10'd10 + {6'd0, 4'(c - "0")};
  assign slash_level = scale_group(acc_r, cnt_r);

  always_comb begin
    mode_nxt = mode_r;
    hash_nxt = hash_r;
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    gidx_nxt = gidx_r;
    first_nxt = first_r;
    second_nxt = second_r;
    pct_nxt = pct_r;
    flags_nxt = flags_r;
    cand_nxt = cand_r;
    case (mode_r)
      MODE_START, MODE_WORD: begin
        if (mode_r == MODE_START && c == "#") begin
          mode_nxt = MODE_HASH;
        end else if (cand_in[WORD_RGB] && pos_r == 5'd3) begin
          cand_nxt = cand_in;
          if (lc == ":") mode_nxt = MODE_RGB;
          else if (lc == "i") mode_nxt = MODE_RGBI_COLON;
          else mode_nxt = MODE_BAD;
        end else begin
          cand_nxt = keep;
          mode_nxt = MODE_WORD;
          if (keep[WORD_GRAY] && pos_r == 5'd3) begin
            mode_nxt = MODE_GRAY;
            pct_nxt = 7'd0;
            flags_nxt = 3'd0;
          end else if (keep == 8'd0) begin
            mode_nxt = MODE_BAD;
          end
        end
      end
      MODE_HASH: begin
        if (!hex_ok || pos_r > 5'd12) mode_nxt = MODE_BAD;
        else hash_nxt = {hash_r[43:0], hex_val};
      end
      MODE_RGB: begin
        if (hex_ok) begin
          if (cnt_r >= 3'd4) begin
            mode_nxt = MODE_BAD;
          end else begin
            acc_nxt = {acc_r[11:0], hex_val};
            cnt_nxt = cnt_r + 3'd1;
          end
        end else if (c == "/" && cnt_r != 3'd0 && gidx_r < 2'd2) begin
          if (gidx_r == 2'd0) first_nxt = slash_level;
          else second_nxt = slash_level;
          gidx_nxt = gidx_r + 2'd1;
          acc_nxt = 16'd0;
          cnt_nxt = 3'd0;
        end else begin
          mode_nxt = MODE_BAD;
        end
      end
      MODE_RGBI_COLON: mode_nxt = (c == ":") ? MODE_RGBI : MODE_BAD;
      MODE_RGBI: mode_nxt = MODE_RGBI;
      MODE_GRAY: begin
        if (c >= "0" && c <= "9") begin
          pct_nxt = (pct_sum > 10'd100) ? 7'd101 : pct_sum[6:0];
          flags_nxt[PF_DIGIT] = 1'b1;
        end else if (flags_r == 3'd0 && (c inside {8'h20, [8'h09:8'h0D]})) begin
          mode_nxt = MODE_GRAY;
        end else if (!flags_r[PF_SIGN] && !flags_r[PF_DIGIT] && (c == "+" || c == "-")) begin
          flags_nxt[PF_SIGN] = 1'b1;
          flags_nxt[PF_NEG] = (c == "-");
        end else begin
          mode_nxt = MODE_BAD;
        end
      end
      default: mode_nxt = MODE_BAD;
    endcase
    pos_nxt = (pos_r < 5'd31) ? pos_r + 5'd1 : 5'd31;
  end

  // Hex groups of the hash form, picked by the number of digits seen.
  always_comb begin
    grp_r = 16'd0;
    grp_g = 16'd0;
    grp_b = 16'd0;
    grp_digits = 3'd0;
    case (pos_r)
      5'd3: begin
        grp_r = {12'd0, hash_nxt[11:8]};
        grp_g = {12'd0, hash_nxt[7:4]};
        grp_b = {12'd0, hash_nxt[3:0]};
        grp_digits = 3'd1;
      end
      5'd6: begin
        grp_r = {8'd0, hash_nxt[23:16]};
        grp_g = {8'd0, hash_nxt[15:8]};
        grp_b = {8'd0, hash_nxt[7:0]};
        grp_digits = 3'd2;
      end
      5'd9: begin
        grp_r = {4'd0, hash_nxt[35:24]};
        grp_g = {4'd0, hash_nxt[23:12]};
        grp_b = {4'd0, hash_nxt[11:0]};
        grp_digits = 3'd3;
      end
      5'd12: begin
        grp_r = hash_nxt[47:32];
        grp_g = hash_nxt[31:16];
        grp_b = hash_nxt[15:0];
        grp_digits = 3'd4;
      end
      default: grp_digits = 3'd0;
    endcase
  end

  always_comb begin
    step_out = '0;
    step_out.parse_status = ST_INVALID;
    case (mode_nxt)
      MODE_HASH: begin
        if (grp_digits != 3'd0) begin
          step_out.red_level = scale_group(grp_r, grp_digits);
          step_out.green_level = scale_group(grp_g, grp_digits);
          step_out.blue_level = scale_group(grp_b, grp_digits);
          step_out.parse_status = ST_VALID;
        end
      end
      MODE_RGB: begin
        if (gidx_nxt == 2'd2 && cnt_nxt != 3'd0) begin
          step_out.red_level = first_nxt;
          step_out.green_level = second_nxt;
          step_out.blue_level = scale_group(acc_nxt, cnt_nxt);
          step_out.parse_status = ST_VALID;
        end
      end
      MODE_RGBI: step_out.parse_status = ST_RGBI;
      MODE_GRAY: begin
        if (flags_nxt[PF_DIGIT] && pct_nxt <= 7'd100 &&
            !(flags_nxt[PF_NEG] && pct_nxt != 7'd0)) begin
          step_out.red_level = gray_level(pct_nxt);
          step_out.green_level = gray_level(pct_nxt);
          step_out.blue_level = gray_level(pct_nxt);
          step_out.parse_status = ST_VALID;
        end
      end
      MODE_WORD: begin
        for (int i = WORD_FIRST_NAME; i < WORD_COUNT; i++) begin
          if (cand_nxt[i] && ({3'd0, WORD_LEN[i]} == {1'b0, pos_r} + 6'd1)) begin
            step_out.red_level = WORD_RED[i];
            step_out.green_level = WORD_GREEN[i];
            step_out.blue_level = WORD_BLUE[i];
            step_out.parse_status = ST_VALID;
          end
        end
      end
      default: step_out.parse_status = ST_INVALID;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step_en && step_in.last_char)) begin
      mode_r <= MODE_START;
      pos_r <= 5'd0;
      hash_r <= 48'd0;
      acc_r <= 16'd0;
      cnt_r <= 3'd0;
      gidx_r <= 2'd0;
      first_r <= 16'd0;
      second_r <= 16'd0;
      pct_r <= 7'd0;
      flags_r <= 3'd0;
      cand_r <= 8'hFF;
    end else if (step_en) begin
      mode_r <= mode_nxt;
      pos_r <= pos_nxt;
      hash_r <= hash_nxt;
      acc_r <= acc_nxt;
      cnt_r <= cnt_nxt;
      gidx_r <= gidx_nxt;
      first_r <= first_nxt;
      second_r <= second_nxt;
      pct_r <= pct_nxt;
      flags_r <= flags_nxt;
      cand_r <= cand_nxt;
    end
  end

endmodule

### design/color_spec_stream_parser.sv
// Top level of the color name parser: input register, parser core, result register.
// Depends on cssp_pkg, cssp_core and color_spec_stream_parser_macros.svh.
//
// The block takes one character beat per cycle and gives one result beat per name, on its
// final character: red, green and blue levels and a status. A character is first captured in
// the input register, and the parser logic then loads the result register from it, so a result
// is offered from the result register after its last character leaves. The rate of one character
// per cycle is held as long as results are taken; a final character waits in the input
// register only while the result register is still full.
`include "color_spec_stream_parser_macros.svh"

module color_spec_stream_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  cssp_pkg::cssp_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output cssp_pkg::cssp_out_t out_data
);
  import cssp_pkg::*;

  logic      in_v_r;
  cssp_in_t  in_data_r;
  logic      out_valid_r;
  cssp_out_t out_data_r;
  cssp_out_t step_out;
  logic      out_free;
  logic      step_en;

  assign out_free = !out_valid_r || out_ready;
  assign step_en = in_v_r && (!in_data_r.last_char || out_free);
  assign in_ready = !in_v_r || step_en;
  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  cssp_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (step_en),
    .step_in  (in_data_r),
    .step_out (step_out)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) in_v_r <= in_valid;
      if (step_en && in_data_r.last_char) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_data_r <= in_data;
    if (step_en && in_data_r.last_char) out_data_r <= step_out;
  end

  `CSSP_ASSERT(a_status_zero, out_valid_r && (out_data_r.parse_status != ST_VALID) |-> (out_data_r.red_level == 16'd0) && (out_data_r.green_level == 16'd0) && (out_data_r.blue_level == 16'd0), "Levels are nonzero on a result that is not valid.")
  `CSSP_ASSERT(a_last_gives_beat, step_en && in_data_r.last_char |=> out_valid_r, "A final character did not load the result register.")
  `CSSP_ASSERT(a_beat_from_last, $rose(out_valid_r) |-> $past(step_en && in_data_r.last_char), "A result beat appeared without a final character.")
  `CSSP_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid_r && !in_v_r, "Registers hold beats after reset.")

endmodule

### tb/sv/tb_color_spec_stream_parser.sv
`timescale 1ns / 1ps
// Self-checking testbench for color_spec_stream_parser: directed and random color names.
// Holds a scoreboard class that predicts each name's levels and status from its characters.
// Depends on cssp_pkg and the color_spec_stream_parser RTL.
module tb_color_spec_stream_parser;
  import cssp_pkg::*;

  localparam int CHAR_TARGET = 1550;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int PCT_NEG = 0;
  localparam int PCT_SIGN = 1;
  localparam int PCT_DIGIT = 2;

  typedef enum logic [3:0] {
    FM_START, FM_WORD, FM_HASH, FM_RGB, FM_RGBI_COLON, FM_RGBI, FM_GRAY, FM_BAD
  } form_mode_e;

  class color_scoreboard;
    cssp_out_t expected_q[$];
    int errors;
    int results_checked;
    int status_seen[3];
    form_mode_e mode;
    logic [4:0] pos;
    logic [47:0] hash_digits;
    logic [15:0] grp_acc;
    logic [2:0] grp_digits;
    logic [1:0] grp_idx;
    logic [15:0] lvl_first;
    logic [15:0] lvl_second;
    logic [7:0] pct;
    logic [2:0] pct_flags;
    logic [7:0] cand;

    function new();
      clear_name();
    endfunction

    function void clear_name();
      mode = FM_START;
      pos = '0;
      hash_digits = '0;
      grp_acc = '0;
      grp_digits = '0;
      grp_idx = '0;
      lvl_first = '0;
      lvl_second = '0;
      pct = '0;
      pct_flags = '0;
      cand = 8'hFF;
    endfunction

    static function string word_text(int i);
      case (i)
        0: return "rgb";
        1: return "gray";
        2: return "black";
        3: return "white";
        4: return "red";
        5: return "green";
        6: return "blue";
        default: return "yellow";
      endcase
    endfunction

    static function logic [47:0] word_rgb(int i);
      case (i)
        3: return {16'hFFFF, 16'hFFFF, 16'hFFFF};
        4: return {16'hFFFF, 16'h0000, 16'h0000};
        5: return {16'h0000, 16'd32896, 16'h0000};
        6: return {16'h0000, 16'h0000, 16'hFFFF};
        7: return {16'hFFFF, 16'hFFFF, 16'h0000};
        default: return '0;
      endcase
    endfunction

    static function logic [7:0] fold(logic [7:0] c);
      return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    static function int hex_nibble(logic [7:0] c);
      logic [7:0] lc;
      lc = fold(c);
      if (c >= "0" && c <= "9") return int'(c) - 48;
      if (lc >= "a" && lc <= "f") return int'(lc) - 87;
      return -1;
    endfunction

    static function logic [15:0] scale_level(longint unsigned v, int n);
      longint unsigned m;
      m = (64'd1 << (4 * n)) - 1;
      return 16'((v * 65535 + m / 2) / m);
    endfunction

    function void word_step(logic [7:0] lc, int p);
      logic [7:0] keep;
      string w;
      if (cand[WORD_RGB] && p == 3) begin
        if (lc == ":") mode = FM_RGB;
        else if (lc == "i") mode = FM_RGBI_COLON;
        else mode = FM_BAD;
        return;
      end
      keep = '0;
      for (int i = 0; i < 8; i++) begin
        w = word_text(i);
        if (cand[i] && p < w.len()) begin
          if (lc == w[p] || (i == WORD_GRAY && p == 2 && lc == "e")) keep[i] = 1'b1;
        end
      end
      cand = keep;
      if (keep[WORD_GRAY] && p == 3) begin
        mode = FM_GRAY;
        pct = '0;
        pct_flags = '0;
      end else if (keep == 0) begin
        mode = FM_BAD;
      end
    endfunction

    function void rgb_step(logic [7:0] c);
      int h;
      logic [15:0] lv;
      h = hex_nibble(c);
      if (h >= 0) begin
        if (grp_digits >= 4) begin
          mode = FM_BAD;
        end else begin
          grp_acc = {grp_acc[11:0], 4'(h)};
          grp_digits = grp_digits + 3'd1;
        end
      end else if (c == "/" && grp_digits > 0 && grp_idx < 2) begin
        lv = scale_level(grp_acc, grp_digits);
        if (grp_idx == 0) lvl_first = lv;
        else lvl_second = lv;
        grp_idx = grp_idx + 2'd1;
        grp_acc = '0;
        grp_digits = '0;
      end else begin
        mode = FM_BAD;
      end
    endfunction

    function void gray_step(logic [7:0] c);
      int v;
      if (c >= "0" && c <= "9") begin
        v = int'(pct) * 10 + int'(c) - 48;
        pct = (v > 100) ? 8'd101 : 8'(v);
        pct_flags[PCT_DIGIT] = 1'b1;
      end else if (pct_flags == 0 && (c == " " || (c >= 8'd9 && c <= 8'd13))) begin
      end else if (!pct_flags[PCT_SIGN] && !pct_flags[PCT_DIGIT] && (c == "+" || c == "-")) begin
        pct_flags[PCT_SIGN] = 1'b1;
        pct_flags[PCT_NEG] = (c == "-");
      end else begin
        mode = FM_BAD;
      end
    endfunction

    function void note_char(cssp_in_t d);
      logic [7:0] c;
      int p;
      int h;
      int n;
      longint unsigned msk;
      cssp_out_t e;
      logic [15:0] gl;
      string w;
      c = d.char_code;
      p = pos;
      case (mode)
        FM_START: begin
          if (c == "#") begin
            mode = FM_HASH;
          end else begin
            cand = 8'hFF;
            mode = FM_WORD;
            word_step(fold(c), p);
          end
        end
        FM_WORD: word_step(fold(c), p);
        FM_HASH: begin
          h = hex_nibble(c);
          if (h < 0 || p > 12) mode = FM_BAD;
          else hash_digits = {hash_digits[43:0], 4'(h)};
        end
        FM_RGB: rgb_step(c);
        FM_RGBI_COLON: mode = (c == ":") ? FM_RGBI : FM_BAD;
        FM_GRAY: gray_step(c);
        FM_RGBI: begin
        end
        default: mode = FM_BAD;
      endcase
      if (pos != 5'd31) pos = pos + 5'd1;
      if (!d.last_char) return;
      e = '0;
      e.parse_status = ST_INVALID;
      case (mode)
        FM_HASH: begin
          if (p == 3 || p == 6 || p == 9 || p == 12) begin
            n = p / 3;
            msk = (64'd1 << (4 * n)) - 1;
            e.blue_level = scale_level(hash_digits & msk, n);
            e.green_level = scale_level((hash_digits >> (4 * n)) & msk, n);
            e.red_level = scale_level((hash_digits >> (8 * n)) & msk, n);
            e.parse_status = ST_VALID;
          end
        end
        FM_RGB: begin
          if (grp_idx == 2 && grp_digits != 0) begin
            e.red_level = lvl_first;
            e.green_level = lvl_second;
            e.blue_level = scale_level(grp_acc, grp_digits);
            e.parse_status = ST_VALID;
          end
        end
        FM_RGBI: e.parse_status = ST_RGBI;
        FM_GRAY: begin
          if (pct_flags[PCT_DIGIT] && pct <= 100 && !(pct_flags[PCT_NEG] && pct != 0)) begin
            gl = 16'((int'(pct) * 255 + 50) / 100 * 257);
            e.red_level = gl;
            e.green_level = gl;
            e.blue_level = gl;
            e.parse_status = ST_VALID;
          end
        end
        FM_WORD: begin
          for (int i = WORD_FIRST_NAME; i < 8; i++) begin
            w = word_text(i);
            if (cand[i] && w.len() == p + 1) begin
              {e.red_level, e.green_level, e.blue_level} = word_rgb(i);
              e.parse_status = ST_VALID;
            end
          end
        end
        default: begin
        end
      endcase
      expected_q.push_back(e);
      clear_name();
    endfunction

    function void check_result(cssp_out_t got);
      cssp_out_t e;
      if (expected_q.size() == 0) begin
        $error("Result beat with no name pending: %0d %0d %0d status %0d",
               got.red_level, got.green_level, got.blue_level, got.parse_status);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      results_checked++;
      status_seen[int'(e.parse_status)]++;
      if (got.red_level !== e.red_level) begin
        $error("red_level expected %0d got %0d", e.red_level, got.red_level);
        errors++;
      end
      if (got.green_level !== e.green_level) begin
        $error("green_level expected %0d got %0d", e.green_level, got.green_level);
        errors++;
      end
      if (got.blue_level !== e.blue_level) begin
        $error("blue_level expected %0d got %0d", e.blue_level, got.blue_level);
        errors++;
      end
      if (got.parse_status !== e.parse_status) begin
        $error("parse_status expected %0d got %0d", e.parse_status, got.parse_status);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  cssp_in_t in_data;
  logic out_valid;
  logic out_ready;
  cssp_out_t out_data;

  color_scoreboard sb = new();
  logic [7:0] name_buf[$];
  int idle_pct;
  bit quiet;
  bit hold_request;
  bit hold_done;
  int sent_chars;
  int name_count;
  int stall_cycles;

  color_spec_stream_parser u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_char(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Timed out after %0d cycles without a beat.", stall_cycles);
      $display("color_spec_stream_parser verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    out_ready = 1'b0;
    hold_done = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (!quiet && idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  function automatic logic [7:0] rand_case(logic [7:0] c);
    if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) return c - 8'd32;
    return c;
  endfunction

  function automatic void put_text(string s, bit mix);
    for (int i = 0; i < s.len(); i++) name_buf.push_back(mix ? rand_case(s[i]) : s[i]);
  endfunction

  function automatic logic [7:0] hex_char();
    string digs;
    digs = "0123456789abcdefABCDEF";
    return digs[$urandom_range(0, 21)];
  endfunction

  function automatic logic [7:0] white_char();
    int v;
    v = $urandom_range(8, 13);
    return (v == 8) ? 8'h20 : 8'(v);
  endfunction

  function automatic string fixed_name();
    case ($urandom_range(0, 5))
      0: return "black";
      1: return "white";
      2: return "red";
      3: return "green";
      4: return "blue";
      default: return "yellow";
    endcase
  endfunction

  function automatic void build_random_name();
    int kind;
    int n;
    int v;
    kind = $urandom_range(0, 99);
    name_buf.delete();
    if (kind < 20) begin
      name_buf.push_back("#");
      n = ($urandom_range(0, 9) < 8) ? 3 * $urandom_range(1, 4) : $urandom_range(0, 35);
      repeat (n) name_buf.push_back(hex_char());
    end else if (kind < 42) begin
      put_text("rgb:", 1);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 4) : 3;
      for (int g = 0; g < n; g++) begin
        v = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 5) : $urandom_range(1, 4);
        repeat (v) name_buf.push_back(hex_char());
        if (g < n - 1) name_buf.push_back("/");
      end
    end else if (kind < 64) begin
      put_text(($urandom_range(0, 1) == 1) ? "gray" : "grey", 1);
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) name_buf.push_back(white_char());
      n = $urandom_range(0, 5);
      if (n == 0) name_buf.push_back("+");
      else if (n == 1) name_buf.push_back("-");
      if ($urandom_range(0, 11) != 0) begin
        repeat (($urandom_range(0, 19) == 0) ? 30 : $urandom_range(0, 1)) name_buf.push_back("0");
        if ($urandom_range(0, 4) == 0) v = 0;
        else if ($urandom_range(0, 9) == 0) v = $urandom_range(101, 99999);
        else v = $urandom_range(0, 100);
        put_text($sformatf("%0d", v), 0);
      end
      if ($urandom_range(0, 11) == 0) name_buf.push_back(white_char());
    end else if (kind < 80) begin
      put_text(fixed_name(), 1);
      if ($urandom_range(0, 7) == 0) void'(name_buf.pop_back());
      else if ($urandom_range(0, 7) == 0) name_buf.push_back(rand_case(8'($urandom_range(97, 122))));
    end else if (kind < 86) begin
      put_text("rgbi:", 1);
      repeat ($urandom_range(0, 6)) name_buf.push_back(8'($urandom_range(1, 255)));
    end else begin
      repeat ($urandom_range(1, 6)) name_buf.push_back(8'($urandom_range(1, 255)));
    end
    if (kind < 86 && $urandom_range(0, 7) == 0)
      name_buf[$urandom_range(0, name_buf.size() - 1)] = 8'($urandom_range(1, 255));
  endfunction

  task automatic send_name();
    for (int i = 0; i < name_buf.size(); i++) begin
      if (!quiet && idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end
      in_data <= cssp_in_t'{char_code: name_buf[i], last_char: (i == name_buf.size() - 1)};
      in_valid <= 1'b1;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      @(negedge clk);
      sent_chars++;
    end
    name_buf.delete();
    name_count++;
  endtask

  task automatic send_text(string s);
    name_buf.delete();
    put_text(s, 0);
    send_name();
  endtask

  initial begin
    string directed[$];
    directed = '{"#000", "#FfF", "#12", "#", "#1a2B3c", "#fedcba987", "#0123456789AB",
                 "#0123456789abc", "rgb:0/8/f", "RGB:ffff/0/1234", "rgb:abc/de/1",
                 "rgb:12345/0/0", "rgb:1//2", "rgb:1/2", "rgbx", "rgbi:1.0/0/0", "RgBi:",
                 "gray", "gray100", "grey 50", "GRAY\t-0", "gray-5", "gray+7", "gray101",
                 "gray99999999", "gray5 ", "black", "White", "RED", "green", "Blue",
                 "yellow", "yellows", "yel"};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    idle_pct = 0;
    quiet = 1'b0;
    hold_request = 1'b0;
    sent_chars = 0;
    name_count = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[i]) send_text(directed[i]);
    name_buf.delete();
    put_text("grey ", 0);
    name_buf.push_back(8'h0B);
    name_buf.push_back(8'h0C);
    put_text("\n\r+042", 0);
    send_name();
    name_buf.delete();
    put_text("gr", 0);
    name_buf.push_back(8'hC1);
    put_text("y5", 0);
    send_name();

    hold_request = 1'b1;
    while (sent_chars < CHAR_TARGET) begin
      if (name_count % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: idle_pct = 0;
          1: idle_pct = 10;
          default: idle_pct = 30;
        endcase
      end
      if (sent_chars > CHAR_TARGET - 200) quiet = 1'b1;
      build_random_name();
      send_name();
    end
    in_valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Sent %0d names in %0d character beats; checked %0d results.",
             name_count, sent_chars, sb.results_checked);
    $display("Statuses seen: %0d valid, %0d invalid, %0d rgbi.",
             sb.status_seen[0], sb.status_seen[1], sb.status_seen[2]);
    if (sb.errors == 0) begin
      $display("color_spec_stream_parser verification clean");
    end else begin
      $display("color_spec_stream_parser verification failed");
    end
    $finish;
  end
endmodule

### filelist.f
+incdir+design
design/cssp_pkg.sv
design/cssp_core.sv
design/color_spec_stream_parser.sv
tb/sv/tb_color_spec_stream_parser.sv
